// ===== hdl/labeled_region_bounding_box_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounding box core
// Shared property forms: same-cycle and next-cycle implication, both
// disabled while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LABELED_REGION_BOUNDING_BOX_CORE_MACROS_SVH
`define LABELED_REGION_BOUNDING_BOX_CORE_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define BBOX_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// ante holds -> cons holds in the next cycle
`define BBOX_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bbox_pkg.sv =====
// ----------------------------------------------------------------------------
// bbox_pkg
// Action codes and shared types for the bounding box core.
// ----------------------------------------------------------------------------
`default_nettype none

package bbox_pkg;

    localparam int ACTION_BITS = 2;

    typedef logic [ACTION_BITS-1:0] action_t;

    localparam action_t ACT_ACCUM = 2'd0;
    localparam action_t ACT_QUERY = 2'd1;
    localparam action_t ACT_QCLR  = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/bbox_front.sv =====
// ----------------------------------------------------------------------------
// bbox_front
// Input stage: takes beats, drops those that cause no work (background
// accumulate, unused action code) and hands the rest to the op queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bbox_front
    import bbox_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int LABEL_BITS = 12,
    parameter int OP_W       = ACTION_BITS + LABEL_BITS + 3 * COORD_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  enable,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [ACTION_BITS-1:0] s_action,
    input  wire logic [COORD_BITS-1:0] s_pos_x,
    input  wire logic [COORD_BITS-1:0] s_pos_y,
    input  wire logic [COORD_BITS-1:0] s_pos_z,
    input  wire logic [LABEL_BITS-1:0] s_label,
    output logic                       push_valid,
    input  wire logic                  push_ready,
    output logic [OP_W-1:0]            push_data
);

    logic            hold_valid_reg, hold_valid_next;
    logic [OP_W-1:0] hold_data_reg;
    logic            keep;
    logic            accept;

    always_comb begin
        keep = 1'b0;
        unique case (s_action) inside
            ACT_ACCUM: keep = (s_label != '0);
            ACT_QUERY, ACT_QCLR: keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    assign s_ready = enable && (!hold_valid_reg || push_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (accept) begin
            hold_valid_next = keep;
        end else if (push_ready) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_data_reg <= {s_action, s_label, s_pos_z, s_pos_y, s_pos_x};
        end
    end

    assign push_valid = hold_valid_reg;
    assign push_data  = hold_data_reg;

endmodule

`default_nettype wire

// ===== hdl/bbox_queue.sv =====
// ----------------------------------------------------------------------------
// bbox_queue
// Two-entry op queue between the input stage and the box engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bbox_queue #(
    parameter int WIDTH = 62
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bbox_back.sv =====
// ----------------------------------------------------------------------------
// bbox_back
// Box engine: owns the per-label box memory, clears it after reset,
// runs read-modify-write for accumulates and answers queries.
// ----------------------------------------------------------------------------
`default_nettype none

module bbox_back
    import bbox_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int LABEL_BITS = 12,
    parameter int OP_W       = ACTION_BITS + LABEL_BITS + 3 * COORD_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  pop_valid,
    output logic                       pop_ready,
    input  wire logic [OP_W-1:0]       pop_data,
    output logic                       init_done,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_found,
    output logic [COORD_BITS-1:0]      m_low_x,
    output logic [COORD_BITS-1:0]      m_low_y,
    output logic [COORD_BITS-1:0]      m_low_z,
    output logic [COORD_BITS-1:0]      m_high_x,
    output logic [COORD_BITS-1:0]      m_high_y,
    output logic [COORD_BITS-1:0]      m_high_z
);

    localparam int PT_W    = 3 * COORD_BITS;
    localparam int BOX_W   = 2 * PT_W;
    localparam int ENTRY_W = BOX_W + 1;
    localparam int DEPTH   = 1 << LABEL_BITS;

    localparam logic [1:0] ST_INIT = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    // entry: {present, hi_z, hi_y, hi_x, lo_z, lo_y, lo_x}
    logic [ENTRY_W-1:0]    box_mem [DEPTH];

    logic [1:0]            state_reg, state_next;
    logic [LABEL_BITS-1:0] clr_addr_reg, clr_addr_next;
    action_t               op_reg;
    logic [LABEL_BITS-1:0] label_reg;
    logic [PT_W-1:0]       pos_reg;
    logic [ENTRY_W-1:0]    rd_entry_reg;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_found_reg;
    logic [BOX_W-1:0]      m_box_reg;

    logic                  do_pop;
    logic                  out_free;
    logic                  out_load;
    logic                  present;
    logic [PT_W-1:0]       cur_lo, cur_hi, new_lo, new_hi;
    logic                  wr_en;
    logic [LABEL_BITS-1:0] wr_addr;
    logic [ENTRY_W-1:0]    wr_data;

    assign pop_ready = (state_reg == ST_IDLE);
    assign do_pop    = pop_valid && pop_ready;
    assign init_done = (state_reg != ST_INIT);
    assign out_free  = !m_valid_reg || m_ready;

    assign present = rd_entry_reg[ENTRY_W-1];
    assign cur_lo  = rd_entry_reg[PT_W-1:0];
    assign cur_hi  = rd_entry_reg[BOX_W-1:PT_W];

    // per-axis widen; first voxel of a label seeds both corners
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (!present || pos_reg[a*COORD_BITS +: COORD_BITS]
                            < cur_lo[a*COORD_BITS +: COORD_BITS]) begin
                new_lo[a*COORD_BITS +: COORD_BITS] = pos_reg[a*COORD_BITS +: COORD_BITS];
            end else begin
                new_lo[a*COORD_BITS +: COORD_BITS] = cur_lo[a*COORD_BITS +: COORD_BITS];
            end
            if (!present || pos_reg[a*COORD_BITS +: COORD_BITS]
                            > cur_hi[a*COORD_BITS +: COORD_BITS]) begin
                new_hi[a*COORD_BITS +: COORD_BITS] = pos_reg[a*COORD_BITS +: COORD_BITS];
            end else begin
                new_hi[a*COORD_BITS +: COORD_BITS] = cur_hi[a*COORD_BITS +: COORD_BITS];
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        wr_en         = 1'b0;
        wr_addr       = label_reg;
        wr_data       = {1'b1, new_hi, new_lo};
        out_load      = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (&clr_addr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (do_pop) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (op_reg == ACT_ACCUM) begin
                    wr_en      = 1'b1;
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    wr_en      = (op_reg == ACT_QCLR);
                    wr_data    = {1'b0, rd_entry_reg[BOX_W-1:0]};
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // box memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            box_mem[wr_addr] <= wr_data;
        end
        if (do_pop) begin
            rd_entry_reg <= box_mem[pop_data[PT_W +: LABEL_BITS]];
        end
    end

    always_ff @(posedge aclk) begin
        if (do_pop) begin
            op_reg    <= pop_data[PT_W+LABEL_BITS +: ACTION_BITS];
            label_reg <= pop_data[PT_W +: LABEL_BITS];
            pos_reg   <= pop_data[PT_W-1:0];
        end
        if (out_load) begin
            m_found_reg <= present;
            m_box_reg   <= present ? rd_entry_reg[BOX_W-1:0] : '0;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_found  = m_found_reg;
    assign m_low_x  = m_box_reg[0*COORD_BITS +: COORD_BITS];
    assign m_low_y  = m_box_reg[1*COORD_BITS +: COORD_BITS];
    assign m_low_z  = m_box_reg[2*COORD_BITS +: COORD_BITS];
    assign m_high_x = m_box_reg[3*COORD_BITS +: COORD_BITS];
    assign m_high_y = m_box_reg[4*COORD_BITS +: COORD_BITS];
    assign m_high_z = m_box_reg[5*COORD_BITS +: COORD_BITS];

endmodule

`default_nettype wire

// ===== hdl/labeled_region_bounding_box_core.sv =====
// ----------------------------------------------------------------------------
// labeled_region_bounding_box_core
// Per-label 3-D bounding box accumulator with query and query-and-clear.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per voxel or query (s_action, s_pos_*, s_label).
//   Accumulate beats with label 0 and beats with action code 3 are dropped.
//   m_ channel: one beat per query: m_found and the box corners; an absent
//   label reads back found = 0 with all corners zero.
//   A query goes through the input register, op queue, memory read and
//   result register to m_valid. The box engine reads the single box memory,
//   then computes and writes back, before it takes the next queued op;
//   dropped beats are consumed at the input stage.
//   A two-entry op queue lets the input side keep taking beats while the
//   engine or the result register is held.
//   After reset the engine sweeps all 2^LABEL_BITS box memory entries
//   with s_ready low.
//   When m_ready is low the result is held; the engine stalls at the next
//   query, and s_ready drops once the queue and input stage are full.
// ----------------------------------------------------------------------------
`default_nettype none

module labeled_region_bounding_box_core
    import bbox_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int LABEL_BITS = 12
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [ACTION_BITS-1:0] s_action,
    input  wire logic [COORD_BITS-1:0]  s_pos_x,
    input  wire logic [COORD_BITS-1:0]  s_pos_y,
    input  wire logic [COORD_BITS-1:0]  s_pos_z,
    input  wire logic [LABEL_BITS-1:0]  s_label,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_found,
    output logic [COORD_BITS-1:0]       m_low_x,
    output logic [COORD_BITS-1:0]       m_low_y,
    output logic [COORD_BITS-1:0]       m_low_z,
    output logic [COORD_BITS-1:0]       m_high_x,
    output logic [COORD_BITS-1:0]       m_high_y,
    output logic [COORD_BITS-1:0]       m_high_z
);

    localparam int OP_W = ACTION_BITS + LABEL_BITS + 3 * COORD_BITS;

    logic            init_done;
    logic            push_valid, push_ready;
    logic [OP_W-1:0] push_data;
    logic            pop_valid, pop_ready;
    logic [OP_W-1:0] pop_data;

    bbox_front #(
        .COORD_BITS (COORD_BITS),
        .LABEL_BITS (LABEL_BITS),
        .OP_W       (OP_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .enable     (init_done),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_pos_x    (s_pos_x),
        .s_pos_y    (s_pos_y),
        .s_pos_z    (s_pos_z),
        .s_label    (s_label),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bbox_queue #(
        .WIDTH (OP_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bbox_back #(
        .COORD_BITS (COORD_BITS),
        .LABEL_BITS (LABEL_BITS),
        .OP_W       (OP_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .init_done (init_done),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_found   (m_found),
        .m_low_x   (m_low_x),
        .m_low_y   (m_low_y),
        .m_low_z   (m_low_z),
        .m_high_x  (m_high_x),
        .m_high_y  (m_high_y),
        .m_high_z  (m_high_z)
    );

endmodule

`default_nettype wire

// ===== hdl/bbox_checker.sv =====
// ----------------------------------------------------------------------------
// bbox_checker
// Port-level checks for the bounding box core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "labeled_region_bounding_box_core_macros.svh"

module bbox_checker #(
    parameter int COORD_BITS = 16,
    parameter int LABEL_BITS = 12
) (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic [1:0]            s_action,
    input wire logic [COORD_BITS-1:0] s_pos_x,
    input wire logic [COORD_BITS-1:0] s_pos_y,
    input wire logic [COORD_BITS-1:0] s_pos_z,
    input wire logic [LABEL_BITS-1:0] s_label,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic                  m_found,
    input wire logic [COORD_BITS-1:0] m_low_x,
    input wire logic [COORD_BITS-1:0] m_low_y,
    input wire logic [COORD_BITS-1:0] m_low_z,
    input wire logic [COORD_BITS-1:0] m_high_x,
    input wire logic [COORD_BITS-1:0] m_high_y,
    input wire logic [COORD_BITS-1:0] m_high_z
);

    logic                              corners_zero;
    logic                              corners_ordered;
    logic [LABEL_BITS+3*COORD_BITS+1:0] s_beat;

    assign corners_zero = (m_low_x == '0) && (m_low_y == '0) && (m_low_z == '0)
                       && (m_high_x == '0) && (m_high_y == '0) && (m_high_z == '0);
    assign corners_ordered = (m_low_x <= m_high_x) && (m_low_y <= m_high_y)
                          && (m_low_z <= m_high_z);
    assign s_beat = {s_action, s_label, s_pos_z, s_pos_y, s_pos_x};

    // held result beat must stay up
    `BBOX_ASSERT_NXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "m_valid dropped")

    // missing box reads back as all-zero corners
    `BBOX_ASSERT_NOW(a_absent_zero, aclk, aresetn, m_valid && !m_found, corners_zero, "absent box not zero")

    // a present box is never inverted on any axis
    `BBOX_ASSERT_NOW(a_box_order, aclk, aresetn, m_valid && m_found, corners_ordered, "box corners inverted")

    // memory sweep keeps the input closed right after reset
    `BBOX_ASSERT_NOW(a_init_closed, aclk, aresetn, !$past(aresetn), !s_ready, "input open during sweep")

    // a waiting input beat keeps valid and payload
    `BBOX_ASSERT_NXT(a_s_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_beat), "input beat changed")

endmodule

bind labeled_region_bounding_box_core bbox_checker #(
    .COORD_BITS (COORD_BITS),
    .LABEL_BITS (LABEL_BITS)
) u_bbox_checker (.*);

`default_nettype wire
